### src/fmnco_pkg.sv
// Shared types and constants of the FM modulator NCO.
`default_nettype none

package fmnco_pkg;

  // Fixed-point constants of the sine table
  localparam int unsigned QFRAC         = 30;
  localparam int unsigned POINT_W       = 31;
  localparam int unsigned GAIN_SHIFT    = 16;
  localparam int unsigned MAX_FRAC_BITS = 16;
  localparam logic [30:0] HALF_PI_Q30   = 31'd1686629713;
  localparam logic [30:0] ONE_Q30       = 31'h4000_0000;
  localparam logic [14:0] AMPLITUDE     = 15'h7FFF;
  localparam logic [31:0] GAIN_RESET    = 32'd85901967;

  // Table generator sequence
  typedef enum logic [2:0] {
    GEN_X,
    GEN_X2,
    GEN_MUL,
    GEN_DIV,
    GEN_SUB,
    GEN_SINE,
    GEN_WRITE,
    GEN_DONE
  } gen_state_e;

  // Status from the table generator to the datapath
  typedef struct packed {
    logic wr_en;
    logic done;
  } gen_status_t;

endpackage : fmnco_pkg

`default_nettype wire

### src/fmnco_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module fmnco_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 4097
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read two words, hold when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule : fmnco_ram

`default_nettype wire

### src/fmnco_table_gen.sv
// Sequencer that computes the quarter-wave sine points after reset.
`default_nettype none

module fmnco_table_gen
  import fmnco_pkg::*;
#(
  parameter int unsigned TABLE_ADDR_BITS = 12
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  output gen_status_t                     status_o,
  output logic [TABLE_ADDR_BITS:0]        waddr_o,
  output logic [POINT_W-1:0]              wdata_o
);

  localparam int unsigned KW = TABLE_ADDR_BITS + 1;
  localparam logic [KW-1:0] K_LAST = KW'(2**TABLE_ADDR_BITS);

  // Scaled reciprocals of the odd part of each divisor, rounded up
  localparam logic [31:0] RCP_3   = 32'(((64'd1 << 33) + 64'd2) / 64'd3);
  localparam logic [31:0] RCP_5   = 32'(((64'd1 << 34) + 64'd4) / 64'd5);
  localparam logic [31:0] RCP_9   = 32'(((64'd1 << 35) + 64'd8) / 64'd9);
  localparam logic [31:0] RCP_21  = 32'(((64'd1 << 36) + 64'd20) / 64'd21);
  localparam logic [31:0] RCP_39  = 32'(((64'd1 << 37) + 64'd38) / 64'd39);
  localparam logic [31:0] RCP_55  = 32'(((64'd1 << 37) + 64'd54) / 64'd55);
  localparam logic [31:0] RCP_105 = 32'(((64'd1 << 38) + 64'd104) / 64'd105);

  gen_state_e state_q, state_d;

  logic [KW-1:0]      k_q;
  logic [30:0]        x_q;
  logic [31:0]        x2_q;
  logic [30:0]        r_q;
  logic [2:0]         n_q;
  logic [31:0]        quo_q;
  logic [POINT_W-1:0] s_q;

  logic [KW+30:0] xk_prod;
  logic [61:0]    xx_prod;
  logic [62:0]    xr2_prod;
  logic [61:0]    xs_prod;
  logic [1:0]     div_pre;
  logic [31:0]    div_rcp;
  logic [5:0]     div_post;
  logic [30:0]    div_num;
  logic [62:0]    div_prod;
  logic [31:0]    div_quo;

  // One multiplier for each state that needs one
  assign xk_prod  = (KW+31)'(k_q) * (KW+31)'(HALF_PI_Q30);
  assign xx_prod  = 62'(x_q) * 62'(x_q);
  assign xr2_prod = 63'(x2_q) * 63'(r_q);
  assign xs_prod  = 62'(x_q) * 62'(r_q);

  // Divide by 2n(2n+1): drop its power of two, then multiply by the
  // reciprocal of the odd part and shift
  always_comb begin
    case (n_q)
      3'd7: begin
        div_pre = 2'd1; div_rcp = RCP_105; div_post = 6'd38;
      end
      3'd6: begin
        div_pre = 2'd2; div_rcp = RCP_39;  div_post = 6'd37;
      end
      3'd5: begin
        div_pre = 2'd1; div_rcp = RCP_55;  div_post = 6'd37;
      end
      3'd4: begin
        div_pre = 2'd3; div_rcp = RCP_9;   div_post = 6'd35;
      end
      3'd3: begin
        div_pre = 2'd1; div_rcp = RCP_21;  div_post = 6'd36;
      end
      3'd2: begin
        div_pre = 2'd2; div_rcp = RCP_5;   div_post = 6'd34;
      end
      default: begin
        div_pre = 2'd1; div_rcp = RCP_3;   div_post = 6'd33;
      end
    endcase
  end

  assign div_num  = 31'(quo_q >> div_pre);
  assign div_prod = 63'(div_num) * 63'(div_rcp);
  assign div_quo  = 32'(div_prod >> div_post);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      GEN_X:     state_d = GEN_X2;
      GEN_X2:    state_d = GEN_MUL;
      GEN_MUL:   state_d = GEN_DIV;
      GEN_DIV:   state_d = GEN_SUB;
      GEN_SUB:   state_d = (n_q == 3'd1) ? GEN_SINE : GEN_MUL;
      GEN_SINE:  state_d = GEN_WRITE;
      GEN_WRITE: state_d = (k_q == K_LAST) ? GEN_DONE : GEN_X;
      GEN_DONE:  state_d = GEN_DONE;
      default:   state_d = GEN_X;
    endcase
  end

  // Outputs
  always_comb begin
    status_o.wr_en = (state_q == GEN_WRITE);
    status_o.done  = (state_q == GEN_DONE);
  end

  assign waddr_o = k_q;
  assign wdata_o = s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GEN_X;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == GEN_WRITE && k_q != K_LAST) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  // Arithmetic registers of the sequence
  always_ff @(posedge clk_i) begin
    case (state_q)
      GEN_X: begin
        x_q <= xk_prod[TABLE_ADDR_BITS +: 31];
      end
      GEN_X2: begin
        x2_q <= xx_prod[61:30];
        r_q  <= ONE_Q30;
        n_q  <= 3'd7;
      end
      GEN_MUL: begin
        quo_q <= xr2_prod[61:30];
      end
      GEN_DIV: begin
        quo_q <= div_quo;
      end
      GEN_SUB: begin
        r_q <= (quo_q >= 32'(ONE_Q30)) ? '0 : 31'(32'(ONE_Q30) - quo_q);
        n_q <= n_q - 1'b1;
      end
      GEN_SINE: begin
        s_q <= xs_prod[60:30];
      end
      default: begin
      end
    endcase
  end

endmodule : fmnco_table_gen

`default_nettype wire

### src/fm_modulator_nco_top.sv
// Top level of the FM modulator NCO with I/Q output.
//
//  channel     direction  width  contents
//  s_axis      in         16     message_sample
//  m_axis      out        32     in_phase, quadrature
//  cfg         in         32     phase_gain
//
// Six pipeline stages: input, multiply, phase accumulate, table read, slope,
// output. One word per cycle while the output is ready. After reset the
// sine table is built by a sequencer, one point at a time, and
// s_axis_tready_o stays low until the table is complete. Each stage holds
// its word while the next is full, so bubbles collapse and a stalled output
// stops only what queues behind it.
`default_nettype none

module fm_modulator_nco_top
  import fmnco_pkg::*;
#(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream: [15:0] message_sample
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,
  // Output stream: [15:0] in_phase, [31:16] quadrature
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [31:0] m_axis_tdata_o,
  // Configuration: phase_gain
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);

  localparam int FB_RAW = int'(PHASE_BITS) - 2 - int'(TABLE_ADDR_BITS);
  localparam int FB = (FB_RAW < 0) ? 0 :
                      ((FB_RAW > int'(MAX_FRAC_BITS)) ? int'(MAX_FRAC_BITS) : FB_RAW);
  localparam int FW    = (FB > 0) ? FB : 1;
  localparam int QB    = int'(TABLE_ADDR_BITS) + FB;
  localparam int W     = QB + 2;
  localparam int DEPTH = 2**TABLE_ADDR_BITS + 1;
  localparam int AW    = TABLE_ADDR_BITS + 1;
  localparam int DFW   = POINT_W + FW;
  localparam int VW    = DFW + 16;
  localparam logic [QB:0]   FULL    = {1'b1, {QB{1'b0}}};
  localparam logic [AW-1:0] ADDR_TOP = AW'(DEPTH - 1);

  // Stage valids and enables
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en0, en1, en2, en3, en4, en5;

  logic [31:0]              gain_q;
  logic signed [15:0]       sample_q;
  logic [PHASE_BITS-1:0]    inc_q;
  logic [PHASE_BITS-1:0]    acc_q;
  logic signed [48:0]       prod;
  logic [63:0]              prod_ext;

  gen_status_t              gen_status;
  logic [AW-1:0]            gen_waddr;
  logic [POINT_W-1:0]       gen_wdata;

  logic [W-1:0]             ph_sin;
  logic [W-1:0]             ph_lane [2];
  logic [QB:0]              pos     [2];
  logic [AW-1:0]            addr_a  [2];
  logic [AW-1:0]            addr_b  [2];
  logic [FW-1:0]            frac    [2];
  logic [POINT_W-1:0]       ra      [2];
  logic [POINT_W-1:0]       rb      [2];
  logic [POINT_W-1:0]       ds      [2];
  logic [VW-1:0]            val     [2];
  logic [14:0]              mag     [2];
  logic [15:0]              smp_d   [2];

  logic [FW-1:0]            f3_q    [2];
  logic                     neg3_q  [2];
  logic [DFW-1:0]           dsf4_q  [2];
  logic [POINT_W-1:0]       sa4_q   [2];
  logic                     neg4_q  [2];
  logic [15:0]              out_q   [2];

  // Enable chain: a stage loads when empty or when the next one loads
  assign en5 = !v5_q || m_axis_tready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;

  assign s_axis_tready_o = en0 && gen_status.done;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      gain_q <= GAIN_RESET;
      acc_q  <= '0;
    end else begin
      if (en0) v0_q <= s_axis_tvalid_i && gen_status.done;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (cfg_valid_i) begin
        gain_q <= cfg_data_i;
      end
      // Advance the phase once for each word
      if (en2 && v1_q) begin
        acc_q <= acc_q + inc_q;
      end
    end
  end

  // Take the input word
  always_ff @(posedge clk_i) begin
    if (en0 && s_axis_tvalid_i) begin
      sample_q <= s_axis_tdata_i;
    end
  end

  // Scale the sample into a phase step, floor shift
  assign prod     = sample_q * $signed({1'b0, gain_q});
  assign prod_ext = {{15{prod[48]}}, prod};

  always_ff @(posedge clk_i) begin
    if (en1 && v0_q) begin
      inc_q <= prod_ext[GAIN_SHIFT +: PHASE_BITS];
    end
  end

  // Align the accumulator onto quadrant, table and fraction bits
  generate
    if (int'(PHASE_BITS) >= W) begin : g_ph_trunc
      assign ph_sin = acc_q[PHASE_BITS-1 -: W];
    end else begin : g_ph_pad
      assign ph_sin = {acc_q, {(W - int'(PHASE_BITS)){1'b0}}};
    end
  endgenerate

  // Lane 0 is cosine (quarter turn ahead), lane 1 is sine
  assign ph_lane[0] = {ph_sin[W-1 -: 2] + 2'd1, ph_sin[QB-1:0]};
  assign ph_lane[1] = ph_sin;

  // Mirror odd quadrants and form table addresses
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      pos[l]    = ph_lane[l][QB] ? (FULL - {1'b0, ph_lane[l][QB-1:0]})
                                 : {1'b0, ph_lane[l][QB-1:0]};
      addr_a[l] = pos[l][QB:FB];
      addr_b[l] = (addr_a[l] == ADDR_TOP) ? addr_a[l] : addr_a[l] + 1'b1;
      if (FB > 0) begin
        frac[l] = pos[l][FW-1:0];
      end else begin
        frac[l] = '0;
      end
    end
  end

  // Sine point tables, one copy per lane
  fmnco_table_gen #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_o(gen_status),
    .waddr_o (gen_waddr),
    .wdata_o (gen_wdata)
  );

  generate
    for (genvar l = 0; l < 2; l++) begin : g_lane_ram
      fmnco_ram #(
        .WIDTH(POINT_W),
        .DEPTH(DEPTH)
      ) u_ram (
        .clk_i    (clk_i),
        .we_i     (gen_status.wr_en),
        .waddr_i  (gen_waddr),
        .wdata_i  (gen_wdata),
        .re_i     (en3 && v2_q),
        .raddr_a_i(addr_a[l]),
        .raddr_b_i(addr_b[l]),
        .rdata_a_o(ra[l]),
        .rdata_b_o(rb[l])
      );
    end
  endgenerate

  // Hold fraction and sign beside the table read
  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      for (int l = 0; l < 2; l++) begin
        f3_q[l]   <= frac[l];
        neg3_q[l] <= ph_lane[l][QB+1];
      end
    end
  end

  // Slope times fraction; drop a falling slope
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ds[l] = (rb[l] > ra[l]) ? (rb[l] - ra[l]) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      for (int l = 0; l < 2; l++) begin
        dsf4_q[l] <= DFW'(ds[l]) * DFW'(f3_q[l]);
        sa4_q[l]  <= ra[l];
        neg4_q[l] <= neg3_q[l];
      end
    end
  end

  // Scale to full amplitude, cap and apply the half-wave sign
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      val[l] = (VW'(sa4_q[l]) * VW'(AMPLITUDE))
             + ((VW'(dsf4_q[l]) * VW'(AMPLITUDE)) >> FB);
      mag[l] = (val[l][VW-1:QFRAC] > (VW-QFRAC)'(AMPLITUDE)) ? AMPLITUDE
                                                              : val[l][QFRAC +: 15];
      smp_d[l] = neg4_q[l] ? (16'd0 - {1'b0, mag[l]}) : {1'b0, mag[l]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5 && v4_q) begin
      out_q[0] <= smp_d[0];
      out_q[1] <= smp_d[1];
    end
  end

  assign m_axis_tvalid_o = v5_q;
  assign m_axis_tdata_o  = {out_q[1], out_q[0]};

  // No word enters before the table is complete
  a_table_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |-> gen_status.done)
    else $error("input word accepted before sine table was built");

  // The phase moves only when a word passes the accumulate stage
  a_acc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(en2 && v1_q) |=> $stable(acc_q))
    else $error("phase accumulator changed without a word");

  // Capped magnitude never reaches the most negative code
  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[15:0] != 16'h8000 &&
                         m_axis_tdata_o[31:16] != 16'h8000))
    else $error("output sample outside full scale");

endmodule : fm_modulator_nco_top

`default_nettype wire

### tb/sv/tb_fm_modulator_nco_top.sv
// Self-checking testbench of the FM modulator NCO against a bit-exact I/Q predictor.
`timescale 1ns / 1ps

module tb_fm_modulator_nco_top;
  import fmnco_pkg::*;

  typedef longint unsigned u64_t;

  // Block geometry, kept equal to the instance below
  localparam int PH_BITS   = 32;
  localparam int TBL_BITS  = 12;
  localparam int FRAC_BITS = (PH_BITS - 2 - TBL_BITS > MAX_FRAC_BITS) ?
                             MAX_FRAC_BITS : (PH_BITS - 2 - TBL_BITS);
  localparam int QPOS_BITS = TBL_BITS + FRAC_BITS;
  localparam int PH_W      = QPOS_BITS + 2;
  localparam int TBL_PTS   = 1 << TBL_BITS;
  localparam logic [PH_W-1:0] QUARTER_TURN = 1 << QPOS_BITS;

  localparam int N_ITEMS   = 1050;
  localparam int N_DIR     = 24;
  localparam int CYCLE_CAP = 3_000_000;

  // One output word: [15:0] in_phase, [31:16] quadrature
  typedef struct packed {
    logic [15:0] quadrature;
    logic [15:0] in_phase;
  } iq_word_t;

  typedef enum logic [1:0] {
    ROW_SAMPLE,
    ROW_GAIN
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [31:0] value;
    bit          q_known;
    logic [15:0] q_val;
  } stim_row_t;

  typedef enum logic [1:0] {
    RDY_OPEN,
    RDY_COIN,
    RDY_COMB,
    RDY_TRICKLE
  } rdy_mode_e;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i  = '0;    // [15:0] message_sample
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;          // [15:0] in_phase, [31:16] quadrature
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i      = '0;    // phase_gain

  // Predictor state and the words it still owes
  u64_t          sine_pts [0:TBL_PTS];
  logic [31:0]   gain_model = GAIN_RESET;
  logic [31:0]   phase_model = '0;
  iq_word_t      iq_expected [$];
  stim_row_t     dir_rows [N_DIR];

  int unsigned   n_sent     = 0;
  int unsigned   n_checked  = 0;
  int unsigned   n_gains    = 0;
  int unsigned   n_errors   = 0;
  int unsigned   burst_left = 0;
  int unsigned   cycle_cnt  = 0;
  logic [15:0]   rdy_phase  = '0;
  rdy_mode_e     rdy_mode   = RDY_OPEN;
  iq_word_t      got_word;
  iq_word_t      want_word;

  fm_modulator_nco_top #(
    .PHASE_BITS      (PH_BITS),
    .TABLE_ADDR_BITS (TBL_BITS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Quarter-wave point k: Horner form of the sine series, Q30 times full scale
  function automatic u64_t sine_point(u64_t k);
    u64_t x, x2, r, t;
    int   n;
    x  = (k * u64_t'(HALF_PI_Q30)) >> TBL_BITS;
    x2 = (x * x) >> QFRAC;
    r  = u64_t'(ONE_Q30);
    for (n = 7; n >= 1; n--) begin
      t = ((x2 * r) >> QFRAC) / u64_t'((2 * n) * (2 * n + 1));
      r = (t >= u64_t'(ONE_Q30)) ? 0 : u64_t'(ONE_Q30) - t;
    end
    return ((x * r) >> QFRAC) * u64_t'(AMPLITUDE);
  endfunction

  // Interpolate between neighbours; a falling slope counts as flat
  function automatic u64_t quarter_wave(u64_t pos);
    u64_t idx, frac, a, b;
    idx  = pos >> FRAC_BITS;
    frac = pos & ((u64_t'(1) << FRAC_BITS) - 1);
    a    = sine_pts[idx];
    if (frac == 0) return a;
    b = sine_pts[idx + 1];
    if (b <= a) return a;
    return a + (((b - a) * frac) >> FRAC_BITS);
  endfunction

  // Fold the phase onto the quarter wave, cap and apply the sign
  function automatic logic [15:0] wave_sample(logic [PH_W-1:0] ph);
    logic [1:0]  quad;
    u64_t        u, pos, mag;
    logic [15:0] res;
    quad = ph[PH_W-1 -: 2];
    u    = u64_t'(ph[QPOS_BITS-1:0]);
    pos  = quad[0] ? ((u64_t'(1) << QPOS_BITS) - u) : u;
    mag  = quarter_wave(pos) >> QFRAC;
    if (mag > u64_t'(AMPLITUDE)) mag = u64_t'(AMPLITUDE);
    res = mag[15:0];
    if (quad[1]) res = -res;
    return res;
  endfunction

  // Advance the phase by one sample and produce the I/Q word it gives
  function automatic iq_word_t next_iq(logic [15:0] raw);
    logic signed [15:0] smp;
    longint             prod;
    logic [31:0]        step;
    logic [PH_W-1:0]    ph;
    iq_word_t           w;
    smp  = raw;
    prod = longint'(smp) * longint'({32'd0, gain_model});
    step = 32'(prod >>> GAIN_SHIFT);
    phase_model = phase_model + step;
    ph = phase_model[PH_BITS-1 -: PH_W];
    w.in_phase   = wave_sample(ph + QUARTER_TURN);
    w.quadrature = wave_sample(ph);
    return w;
  endfunction

  // Offer one sample and hold it until taken; log what it must produce
  task automatic send_sample(logic [15:0] raw, bit q_known = 1'b0, logic [15:0] q_val = '0);
    iq_word_t w;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= raw;
    do @(posedge clk_i); while (!s_axis_tready_o);
    w = next_iq(raw);
    if (q_known) w.quadrature = q_val;
    iq_expected.push_back(w);
    n_sent++;
  endtask

  // End a burst now and then with a random gap
  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_drain();
    while (iq_expected.size() != 0) @(posedge clk_i);
  endtask

  // Drain the pipe, then load a new gain
  task automatic write_gain(logic [31:0] value);
    s_axis_tvalid_i <= 1'b0;
    wait_drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    gain_model = value;
    n_gains++;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      1: return 16'($signed($urandom_range(0, 510)) - 255);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return GAIN_RESET;
      3: return 32'h8000_0000;
      4: return 32'($urandom_range(1, 65535));
      default: return $urandom();
    endcase
  endfunction

  // Receiver: pick a new stall style whenever the low byte of rdy_phase is zero
  always @(posedge clk_i) begin
    rdy_phase <= rdy_phase + 16'd1;
    if (rdy_phase[7:0] == 8'd0) rdy_mode <= rdy_mode_e'($urandom_range(0, 3));
    case (rdy_mode)
      RDY_OPEN:    m_axis_tready_i <= 1'b1;
      RDY_COIN:    m_axis_tready_i <= 1'($urandom_range(0, 1));
      RDY_COMB:    m_axis_tready_i <= (rdy_phase[2:0] != 3'd3) && (rdy_phase[2:0] != 3'd6);
      RDY_TRICKLE: m_axis_tready_i <= (rdy_phase[3:0] == 4'd0);
      default:     m_axis_tready_i <= 1'b1;
    endcase
  end

  // Compare each word taken from the block with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_word = m_axis_tdata_o;
      if (iq_expected.size() == 0) begin
        n_errors++;
        $display("%0t: word %h with nothing expected", $time, m_axis_tdata_o);
      end else begin
        want_word = iq_expected.pop_front();
        if (got_word.in_phase !== want_word.in_phase) begin
          n_errors++;
          $display("%0t: in_phase expected %0d got %0d", $time,
                   $signed(want_word.in_phase), $signed(got_word.in_phase));
        end
        if (got_word.quadrature !== want_word.quadrature) begin
          n_errors++;
          $display("%0t: quadrature expected %0d got %0d", $time,
                   $signed(want_word.quadrature), $signed(got_word.quadrature));
        end
        n_checked++;
      end
    end
  end

  // Timeout; covers the table build after reset
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("%0t: timeout, %0d words still owed", $time, iq_expected.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int i;
    int unsigned seg;

    for (i = 0; i <= TBL_PTS; i++) sine_pts[i] = sine_point(u64_t'(i));

    // Zero phase after reset gives zero sine; then gain extremes and wraps
    dir_rows = '{
      '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 16'h0000},
      '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 16'h0000},
      '{ROW_SAMPLE, 32'h0000_7FFF, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 32'h0000_8000, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 32'h0000_0001, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 32'h0000_FFFF, 1'b0, 16'h0000},
      '{ROW_GAIN,   32'h8000_0000, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 32'h0000_8000, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 32'h0000_8000, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 32'h0000_8000, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 32'h0000_8000, 1'b0, 16'h0000},
      '{ROW_GAIN,   32'h0000_0000, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 32'h0000_7FFF, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 32'h0000_8000, 1'b0, 16'h0000},
      '{ROW_GAIN,   32'hFFFF_FFFF, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 32'h0000_7FFF, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 32'h0000_7FFF, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 32'h0000_8000, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 32'h0000_5555, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 32'h0000_AAAA, 1'b0, 16'h0000},
      '{ROW_GAIN,   32'h0000_0001, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 32'h0000_FFFF, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 32'h0000_0001, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 32'h0000_8000, 1'b0, 16'h0000}
    };

    // Hold reset, then release on an edge
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].kind == ROW_GAIN) begin
        write_gain(dir_rows[i].value);
      end else begin
        send_sample(dir_rows[i].value[15:0], dir_rows[i].q_known, dir_rows[i].q_val);
        pace();
      end
    end

    // Random segments, each under a fresh gain
    while (n_sent < N_ITEMS) begin
      write_gain(pick_gain());
      seg = $urandom_range(20, 160);
      while (seg != 0 && n_sent < N_ITEMS) begin
        send_sample(pick_sample());
        pace();
        if ((n_sent % 256) == 128 || $urandom_range(0, 199) == 0) begin
          s_axis_tvalid_i <= 1'b0;
          wait_drain();
        end
        seg--;
      end
    end

    // Let the pipe empty and catch any stray word
    s_axis_tvalid_i <= 1'b0;
    wait_drain();
    repeat (16) @(posedge clk_i);

    $display("Summary: %0d samples in, %0d I/Q words checked, %0d gain loads", n_sent,
             n_checked, n_gains);
    $display("Gains included zero, one, half range, all ones and the reset value.");
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
